// ===== hw/rtl/assert_macros.svh =====
// Assertion shorthands for the sharpening filter.
// Used by the top level only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/lss_pkg.sv =====
// Shared types and constants of the Laplacian sharpening filter.
// No dependencies; every RTL module and interface imports this package.
package lss_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int IROW_W     = 13;   // input row runs past the last row while draining
  localparam int OROW_W     = 12;
  localparam int HGT_W      = 13;
  localparam int CFGW_W     = 11;   // width register as written

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam int                 WIDTH_RESET  = 640;
  localparam logic [HGT_W-1:0]   HEIGHT_RESET = 13'd480;
  localparam logic [HGT_W-1:0]   HEIGHT_LIMIT = 13'd4096;
  localparam logic [PIX_W-1:0]   PIX_MAX      = 8'hFF;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_CNT_W = 3;
  localparam int FIFO_PTR_W = 2;
  // one slot stays free for the item in the kernel stage
  localparam logic [FIFO_CNT_W-1:0] FIFO_READY_LIM = 3'd3;

  // Per-item control carried from the sequencer into the kernel stage.
  typedef struct packed {
    logic             adv;      // item advances the stream
    logic             emit;     // item produces an output pixel
    logic             last;     // output is the frame's last pixel
    logic             n_edge;   // top row: north replicates center
    logic             s_edge;   // bottom row
    logic             w_edge;   // left column
    logic             e_edge;   // right column
    logic [PIX_W-1:0] pixel;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] sharpened;
    logic             frame_last;
  } out_t;

endpackage

// ===== hw/rtl/lss_ifaces.sv =====
// Handshake channel interfaces of the sharpening filter: pixel input,
// result output and configuration write. Depends on lss_pkg.
interface lss_in_if import lss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, mode, pixel, input ready);
  modport sink   (input valid, mode, pixel, output ready);
endinterface

interface lss_out_if import lss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] sharpened;
  logic             frame_last;
  modport source (output valid, sharpened, frame_last, input ready);
  modport sink   (input valid, sharpened, frame_last, output ready);
endinterface

interface lss_cfg_if import lss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/lss_seq.sv =====
// Stream sequencer: frame size registers, input/output position counters,
// edge flags and the per-item control word. Depends on lss_pkg.
module lss_seq import lss_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  acc_i,
  input  logic                  mode_i,
  input  logic [PIX_W-1:0]      pixel_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  issue_o,
  output logic [$clog2(MAX_WIDTH)-1:0] issue_col_o,
  output logic [PIX_W-1:0]      issue_pix_o,
  output item_t                 item_o
);

  localparam int ColW       = $clog2(MAX_WIDTH);
  localparam int WW         = ColW + 1;
  localparam int WidthReset = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  logic [WW-1:0]     wid_q;
  logic [HGT_W-1:0]  hgt_q;
  logic [ColW-1:0]   in_col_q, in_col_d, out_col_q, out_col_d;
  logic [IROW_W-1:0] in_row_q, in_row_d;
  logic [OROW_W-1:0] out_row_q, out_row_d;
  item_t             item_q, item_d;

  logic [WW-1:0]     wid_m1;
  logic [HGT_W-1:0]  hgt_m1;
  logic              frame_done, restart, ignore;
  logic [ColW-1:0]   in_col_c, out_col_c;
  logic [IROW_W-1:0] in_row_c;
  logic [OROW_W-1:0] out_row_c;
  logic [HGT_W-1:0]  wv, hv, w_new, h_new;

  assign wid_m1 = wid_q - WW'(1);
  assign hgt_m1 = hgt_q - HGT_W'(1);

  assign frame_done = (in_row_q >= IROW_W'(hgt_q));
  assign restart    = !mode_i && frame_done;      // pixel after the frame starts a new one
  assign ignore     = mode_i && !frame_done;      // drain before the frame is complete

  assign in_col_c  = restart ? '0 : in_col_q;
  assign in_row_c  = restart ? '0 : in_row_q;
  assign out_col_c = restart ? '0 : out_col_q;
  assign out_row_c = restart ? '0 : out_row_q;

  always_comb begin
    item_d        = '0;
    item_d.adv    = acc_i && !ignore;
    item_d.emit   = (in_row_c >= IROW_W'(2)) || ((in_row_c == IROW_W'(1)) && (in_col_c != '0));
    item_d.n_edge = (out_row_c == '0);
    item_d.s_edge = ({1'b0, out_row_c} >= hgt_m1);
    item_d.w_edge = (out_col_c == '0);
    item_d.e_edge = ({1'b0, out_col_c} >= wid_m1);
    item_d.last   = item_d.s_edge && item_d.e_edge;
    item_d.pixel  = mode_i ? '0 : pixel_i;
  end

  always_comb begin
    in_col_d  = in_col_c;
    in_row_d  = in_row_c;
    out_col_d = out_col_c;
    out_row_d = out_row_c;
    if ({1'b0, in_col_c} == wid_m1) begin
      in_col_d = '0;
      in_row_d = in_row_c + IROW_W'(1);
    end else begin
      in_col_d = in_col_c + ColW'(1);
    end
    if (item_d.emit) begin
      if (item_d.e_edge) begin
        out_col_d = '0;
        out_row_d = out_row_c + OROW_W'(1);
      end else begin
        out_col_d = out_col_c + ColW'(1);
      end
    end
    if (item_d.emit && item_d.last) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  // register values with 0 and oversize clamped
  assign wv    = {{(HGT_W-CFGW_W){1'b0}}, cfg_data_i[CFGW_W-1:0]};
  assign hv    = cfg_data_i[HGT_W-1:0];
  assign w_new = (wv == '0) ? HGT_W'(1) : ((wv > HGT_W'(MAX_WIDTH)) ? HGT_W'(MAX_WIDTH) : wv);
  assign h_new = (hv == '0) ? HGT_W'(1) : ((hv > HEIGHT_LIMIT) ? HEIGHT_LIMIT : hv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q     <= WW'(WidthReset);
      hgt_q     <= HEIGHT_RESET;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      item_q    <= '0;
    end else begin
      item_q <= item_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_IMAGE_WIDTH) begin
          wid_q <= WW'(w_new);
        end
        if (cfg_idx_i == REG_IMAGE_HEIGHT) begin
          hgt_q <= h_new;
        end
        if ((cfg_idx_i == REG_IMAGE_WIDTH) || (cfg_idx_i == REG_IMAGE_HEIGHT)) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end
      end else if (item_d.adv) begin
        in_col_q  <= in_col_d;
        in_row_q  <= in_row_d;
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
      end
    end
  end

  assign issue_o     = item_d.adv;
  assign issue_col_o = in_col_c;
  assign issue_pix_o = item_d.pixel;
  assign item_o      = item_q;

endmodule

// ===== hw/rtl/lss_line_mem.sv =====
// Two row stores (newest row and the one above) with registered reads.
// The upper store is refilled from the middle store's read in the following cycle.
// Depends on lss_pkg.
module lss_line_mem import lss_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         issue_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_i,
  input  logic [PIX_W-1:0]             pix_i,
  input  logic                         s1_adv_i,
  output logic [PIX_W-1:0]             mid_rd_o,
  output logic [PIX_W-1:0]             up_rd_o
);

  localparam int ColW = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] mid_rd_q, up_rd_q;
  logic [ColW-1:0]  col_s1_q;
  logic             fwd;

  // one-column rows: the upper write lands on the entry being read
  assign fwd = s1_adv_i && (col_s1_q == col_i);

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      mid_rd_q      <= mid_mem[col_i];   // read-first
      mid_mem[col_i] <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      up_rd_q  <= fwd ? mid_rd_q : up_mem[col_i];
      col_s1_q <= col_i;
    end
    if (s1_adv_i) begin
      up_mem[col_s1_q] <= mid_rd_q;
    end
  end

  assign mid_rd_o = mid_rd_q;
  assign up_rd_o  = up_rd_q;

endmodule

// ===== hw/rtl/lss_kernel.sv =====
// 3x3 window registers and the Laplacian sharpening arithmetic.
// Depends on lss_pkg.
module lss_kernel import lss_pkg::*; (
  input  logic             clk_i,
  input  item_t            item_i,
  input  logic [PIX_W-1:0] mid_rd_i,   // east of this item's center
  input  logic [PIX_W-1:0] up_rd_i,    // north of the next center
  output logic             push_o,
  output out_t             res_o
);

  logic [PIX_W-1:0] c_q, w_q, n_q, s_q;
  logic [PIX_W-1:0] pc, pn, ps, pw, pe, lap_cl;
  logic [PIX_W+1:0] c4, nsum;
  logic [PIX_W+2:0] lap;
  logic [PIX_W:0]   res;

  always_ff @(posedge clk_i) begin
    if (item_i.adv) begin
      w_q <= c_q;
      c_q <= mid_rd_i;
      n_q <= up_rd_i;
      s_q <= item_i.pixel;
    end
  end

  always_comb begin
    pc = c_q;
    pn = item_i.n_edge ? c_q : n_q;
    ps = item_i.s_edge ? c_q : s_q;
    pw = item_i.w_edge ? c_q : w_q;
    pe = item_i.e_edge ? c_q : mid_rd_i;
    c4   = {pc, 2'b00};
    nsum = {2'b00, pn} + {2'b00, ps} + {2'b00, pw} + {2'b00, pe};
    lap  = {1'b0, c4} - {1'b0, nsum};
    if (lap[PIX_W+2]) begin
      lap_cl = '0;
    end else if (lap[PIX_W+1:PIX_W] != '0) begin
      lap_cl = PIX_MAX;
    end else begin
      lap_cl = lap[PIX_W-1:0];
    end
    res = {1'b0, pc} + {2'b00, lap_cl[PIX_W-1:1]};
    res_o.sharpened  = res[PIX_W] ? PIX_MAX : res[PIX_W-1:0];
    res_o.frame_last = item_i.last;
  end

  assign push_o = item_i.adv && item_i.emit;

endmodule

// ===== hw/rtl/lss_out_fifo.sv =====
// Small result queue that decouples the kernel from output backpressure.
// Depends on lss_pkg.
module lss_out_fifo import lss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  out_t                  data_i,
  input  logic                  pop_i,
  output out_t                  data_o,
  output logic                  valid_o,
  output logic [FIFO_CNT_W-1:0] cnt_o
);

  out_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] head_q, tail_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_pop;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[head_q];
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        tail_q <= tail_q + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        head_q <= head_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(do_pop);
    end
  end

endmodule

// ===== hw/rtl/laplacian_sharpen_3x3.sv =====
// Top level of the 3x3 Laplacian sharpening filter for 8-bit grey rasters.
// Depends on lss_pkg, the channel interfaces, lss_seq, lss_line_mem,
// lss_kernel, lss_out_fifo and assert_macros.svh.
//
// Takes one pixel or drain request per clock and sustains one result per clock;
// a request's row-store reads and control word are registered into the kernel
// stage, whose result is written into a four-entry output queue from which it
// can be taken. The row stores are read-first synchronous memories with
// registered reads. The input stalls while three or more results are queued and
// while a configuration write is offered. Results trail the input stream by
// image_width + 1 requests, so a frame needs image_width + 1 drain requests
// after its last pixel (a one-row frame gets no result from the first). Border
// neighbors replicate the center pixel. Drain requests before the frame is
// complete are taken and do nothing; a pixel sent during an unfinished drain
// drops what is left of the old frame. Writing either size register restarts
// the frame and must only happen while the block is idle; configuration
// writes are always ready. The row stores are not cleared at reset.
`include "assert_macros.svh"

module laplacian_sharpen_3x3 import lss_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lss_in_if.sink     in_i,
  lss_out_if.source  out_o,
  lss_cfg_if.sink    cfg_i
);

  localparam int ColW = $clog2(MAX_WIDTH);

  logic                  in_acc, cfg_we, issue, push;
  logic [ColW-1:0]       issue_col;
  logic [PIX_W-1:0]      issue_pix, mid_rd, up_rd;
  item_t                 item_s1;
  out_t                  res, head;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic                  fifo_valid;

  assign in_i.ready  = (fifo_cnt < FIFO_READY_LIM) && !cfg_i.valid;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  lss_seq #(.MAX_WIDTH(MAX_WIDTH)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .mode_i      (in_i.mode),
    .pixel_i     (in_i.pixel),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .issue_o     (issue),
    .issue_col_o (issue_col),
    .issue_pix_o (issue_pix),
    .item_o      (item_s1)
  );

  lss_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_mem (
    .clk_i    (clk_i),
    .issue_i  (issue),
    .col_i    (issue_col),
    .pix_i    (issue_pix),
    .s1_adv_i (item_s1.adv),
    .mid_rd_o (mid_rd),
    .up_rd_o  (up_rd)
  );

  lss_kernel u_kernel (
    .clk_i    (clk_i),
    .item_i   (item_s1),
    .mid_rd_i (mid_rd),
    .up_rd_i  (up_rd),
    .push_o   (push),
    .res_o    (res)
  );

  lss_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .pop_i   (out_o.ready),
    .data_o  (head),
    .valid_o (fifo_valid),
    .cnt_o   (fifo_cnt)
  );

  assign out_o.valid      = fifo_valid;
  assign out_o.sharpened  = head.sharpened;
  assign out_o.frame_last = head.frame_last;

  // the kernel stage only holds work for a request taken the cycle before
  `LSS_ASSERT_NXT(a_adv_needs_accept, clk_i, rst_ni, !in_acc, !item_s1.adv)
  // a result that is not taken stays offered
  `LSS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready, out_o.valid)
  // the queue never overflows
  `LSS_ASSERT_IMP(a_fifo_room, clk_i, rst_ni,
                  (fifo_cnt == FIFO_CNT_W'(FIFO_DEPTH)) && !out_o.ready, !push)

endmodule

// ===== test/laplacian_sharpen_3x3_tb.sv =====
// Self-checking testbench for laplacian_sharpen_3x3: pixel and drain requests in,
// sharpened pixels checked against an in-bench predictor of the line-store filter.
// Depends on lss_pkg, the lss channel interfaces and the laplacian_sharpen_3x3 RTL.
`timescale 1ns / 1ps

module laplacian_sharpen_3x3_tb;
  import lss_pkg::*;

  localparam int          MAX_W         = 1024;
  localparam int          H_LIMIT       = 4096;
  localparam int          RANDOM_ITEMS  = 300;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          TIMEOUT_NS    = 2_000_000;
  localparam bit          MODE_PIXEL    = 1'b0;
  localparam bit          MODE_DRAIN    = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic clk_i;
  logic rst_ni;

  lss_in_if  in_if ();
  lss_out_if out_if ();
  lss_cfg_if cfg_if ();

  laplacian_sharpen_3x3 #(.MAX_WIDTH(MAX_W)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Predictor state
  logic [CFGW_W-1:0] width_reg;
  logic [HGT_W-1:0]  height_reg;
  logic [PIX_W-1:0]  upper_row  [MAX_W];
  logic [PIX_W-1:0]  middle_row [MAX_W];
  logic [PIX_W-1:0]  held_pix;
  int unsigned       in_col, in_row, out_col, out_row;

  out_t sharp_expected[$];
  int   mismatch_count = 0;
  int   max_send_gap   = 5;
  int   max_recv_stall = 5;
  int   ready_hold_cycles = 0;

  function automatic int unsigned active_width();
    int unsigned w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > H_LIMIT) h = H_LIMIT;
    return h;
  endfunction

  function automatic void restart_frame();
    in_col   = 0;
    in_row   = 0;
    out_col  = 0;
    out_row  = 0;
    held_pix = '0;
  endfunction

  function automatic void sharpen_reset();
    width_reg  = CFGW_W'(WIDTH_RESET);
    height_reg = HEIGHT_RESET;
    for (int i = 0; i < MAX_W; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    restart_frame();
  endfunction

  function automatic void size_config(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = val[CFGW_W-1:0];
      restart_frame();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = val[HGT_W-1:0];
      restart_frame();
    end
  endfunction

  // Advances the stream by one request; returns 1 when it yields an output pixel.
  function automatic bit sharpen_predict(input bit drain, input logic [PIX_W-1:0] pix_in,
                                         output out_t res);
    int unsigned w, h, oc, col;
    int c, n, s, wv, e, lap, sum;
    logic [PIX_W-1:0] pix;
    bit emit, frame_end;
    w = active_width();
    h = active_height();
    pix = pix_in;
    emit = 1'b0;
    frame_end = 1'b0;
    res = '0;
    if (drain) begin
      if (in_row < h) return 1'b0;  // frame not complete: ignored
      pix = '0;
    end else if (in_row >= h) begin
      restart_frame();              // pixel during flush drops the old frame
    end
    if (in_col >= w) in_col = w - 1;
    if (out_col >= w) out_col = w - 1;

    if (in_row >= 2 || (in_row == 1 && in_col >= 1)) begin
      oc  = out_col;
      c   = int'(middle_row[oc]);
      n   = (out_row == 0) ? c : int'(upper_row[oc]);
      s   = (out_row + 1 >= h) ? c : int'(held_pix);
      wv  = (oc == 0) ? c : int'(upper_row[oc - 1]);
      e   = (oc + 1 >= w) ? c : int'(middle_row[oc + 1]);
      lap = 4 * c - n - s - wv - e;
      if (lap < 0) lap = 0;
      if (lap > 255) lap = 255;
      sum = c + lap / 2;
      if (sum > 255) sum = 255;
      frame_end = (out_row + 1 >= h) && (oc + 1 >= w);
      res.sharpened  = sum[PIX_W-1:0];
      res.frame_last = frame_end;
      emit = 1'b1;
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end

    // held pixel is committed to the stores one step late
    if (in_row != 0 || in_col != 0) begin
      col = (in_col == 0) ? w - 1 : in_col - 1;
      upper_row[col]  = middle_row[col];
      middle_row[col] = held_pix;
    end
    held_pix = pix;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (frame_end) restart_frame();
    return emit;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return PIX_MAX;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Called and returns at a falling edge; leaves valid high for a back-to-back request.
  task automatic send_req(input bit drain, input logic [PIX_W-1:0] pix);
    int unsigned gap;
    out_t res;
    gap = $urandom_range(0, max_send_gap);
    cfg_if.valid <= 1'b0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= drain;
    in_if.pixel <= pix;
    do @(posedge clk_i); while (!in_if.ready);
    if (sharpen_predict(drain, pix, res)) sharp_expected.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    size_config(idx, val);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b0;
    while (sharp_expected.size() != 0) @(negedge clk_i);
    // requests with no output may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    logic [CFG_DATA_W-1:0] wdata;
    wdata = CFG_DATA_W'(w);
    wdata[CFG_DATA_W-1:CFGW_W] = 2'($urandom_range(0, 3));  // bits above the width register
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, wdata);
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
  endtask

  task automatic send_frame(input int unsigned w, input int unsigned h,
                            input int unsigned drains, input bit noisy);
    for (int unsigned i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 3) == 0) send_req(MODE_DRAIN, rand_pixel());
      send_req(MODE_PIXEL, rand_pixel());
    end
    for (int unsigned i = 0; i < drains; i++) send_req(MODE_DRAIN, rand_pixel());
  endtask

  // Reset size of 640 x 480: only the first outputs, streamed with no idling.
  task automatic test_default_size();
    max_send_gap   = 0;
    max_recv_stall = 0;
    for (int i = 0; i < 643; i++) send_req(MODE_PIXEL, rand_pixel());
    wait_drained();
  endtask

  task automatic test_directed_patterns();
    logic [PIX_W-1:0] pat [9];
    pat = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
    max_send_gap   = 5;
    max_recv_stall = 5;
    // bright center on dark neighbors saturates, dark center on bright clamps to 0
    set_size(3, 3);
    send_req(MODE_DRAIN, 8'd255);              // early drain, ignored
    foreach (pat[i]) send_req(MODE_PIXEL, pat[i]);
    for (int i = 0; i < 4; i++) send_req(MODE_DRAIN, 8'd0);
    send_req(MODE_DRAIN, 8'd0);                // after frame end, ignored
    // one-row frame: first drain yields nothing
    set_size(2, 1);
    send_req(MODE_PIXEL, 8'd255);
    send_req(MODE_PIXEL, 8'd1);
    for (int i = 0; i < 3; i++) send_req(MODE_DRAIN, 8'd0);
    // flush cut short by the next frame's pixels
    send_req(MODE_PIXEL, 8'd128);
    send_req(MODE_PIXEL, 8'd127);
    send_req(MODE_DRAIN, 8'd0);
    send_req(MODE_PIXEL, 8'd0);
    send_req(MODE_PIXEL, 8'd255);
    for (int i = 0; i < 3; i++) send_req(MODE_DRAIN, 8'd0);
    wait_drained();
  endtask

  task automatic test_size_extremes();
    max_send_gap   = 5;
    max_recv_stall = 5;
    set_size(0, 0);                            // reads as 1 x 1
    send_frame(1, 1, 2, 1'b0);
    wait_drained();
    write_reg(REG_SPARE_2, '1);                // unused indexes change nothing
    write_reg(REG_SPARE_3, '0);
    send_frame(1, 1, 2, 1'b0);
    set_size(2047, 2);                         // width caps at MAX_WIDTH; first outputs only
    for (int i = 0; i < MAX_W + 3; i++) send_req(MODE_PIXEL, rand_pixel());
    set_size(2, 8191);                         // height caps; only the top rows
    for (int i = 0; i < 12; i++) send_req(MODE_PIXEL, rand_pixel());
    set_size(1, H_LIMIT);
    for (int i = 0; i < 6; i++) send_req(MODE_PIXEL, rand_pixel());
    set_size(1, 2);
    send_frame(1, 2, 2, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_frames();
    int unsigned w, h, n_sent, kind, frame_idx, drains;
    n_sent = 0;
    frame_idx = 0;
    w = 4;
    h = 3;
    while (n_sent < RANDOM_ITEMS) begin
      if (frame_idx % 3 == 0) begin
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        set_size(w, h);
      end
      max_send_gap   = ($urandom_range(0, 3) == 0) ? 0 : 5;
      max_recv_stall = ($urandom_range(0, 3) == 0) ? 0 : 5;
      kind = $urandom_range(0, 9);
      drains = (kind == 8) ? $urandom_range(0, w) : w + 1;
      send_frame(w, h, drains, kind == 7);
      if (kind == 9) begin
        for (int i = 0; i < 3; i++) send_req(MODE_DRAIN, rand_pixel());
      end
      n_sent += w * h + drains;
      frame_idx++;
    end
    wait_drained();
  endtask

  // Output held off long enough that the block fills up and stalls its input.
  task automatic test_output_backpressure();
    set_size(16, 6);
    max_send_gap   = 0;
    max_recv_stall = 0;
    ready_hold_cycles = 120;
    send_frame(16, 6, 17, 1'b0);
    wait_drained();
    max_send_gap   = 5;
    max_recv_stall = 5;
  endtask

  initial begin : result_monitor
    int unsigned stall;
    out_t want;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (ready_hold_cycles != 0) begin
        stall = ready_hold_cycles;
        ready_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, max_recv_stall);
      end
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      if (sharp_expected.size() == 0) begin
        $error("unexpected result: sharpened %0d frame_last %0b",
               out_if.sharpened, out_if.frame_last);
        mismatch_count++;
      end else begin
        want = sharp_expected.pop_front();
        if (out_if.sharpened !== want.sharpened) begin
          $error("sharpened: expected %0d, got %0d", want.sharpened, out_if.sharpened);
          mismatch_count++;
        end
        if (out_if.frame_last !== want.frame_last) begin
          $error("frame_last: expected %0b, got %0b", want.frame_last, out_if.frame_last);
          mismatch_count++;
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.mode   = MODE_PIXEL;
    in_if.pixel  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_IMAGE_WIDTH;
    cfg_if.data  = '0;
    sharpen_reset();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_size();
    test_directed_patterns();
    test_size_extremes();
    test_random_frames();
    test_output_backpressure();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
